// ===== rtl/fcls_pkg.sv =====
package fcls_pkg;

	// Width of a reported length field.
	localparam int REC_BITS = 32;

	// Depth of the event queue between front and back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Characters that steer the parser.
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_N_UP = 8'h4E;
	localparam logic [7:0] CH_N_LO = 8'h6E;

	// Record kinds as carried on the output tuser bit.
	localparam logic KIND_CONTIG   = 1'b0;
	localparam logic KIND_SCAFFOLD = 1'b1;

	// One queue entry holds every record that one input word causes:
	// an optional contig record followed by an optional scaffold record.
	typedef struct packed {
		logic                has_contig;
		logic [REC_BITS-1:0] contig_len;
		logic                has_scaffold;
		logic [REC_BITS-1:0] scaffold_len;
	} fcls_evt_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [FIFO_AW:0] count;
	} fcls_fifo_stat_t;

	// True for the IUPAC base letters in either case, '?' and '-'.
	function automatic logic is_base(input logic [7:0] b);
		logic [7:0] up;
		logic       hit;
		up = b;
		if (b >= 8'h61 && b <= 8'h7A) begin
			up = b - 8'h20;
		end
		case (up)
			8'h54, 8'h43, 8'h41, 8'h47, 8'h55, 8'h59, 8'h52, 8'h4D, 8'h4B,
			8'h53, 8'h57, 8'h48, 8'h42, 8'h56, 8'h44, 8'h4E, 8'h3F, 8'h2D: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

// ===== rtl/fasta_contig_length_scanner_top.sv =====
// FASTA contig length scanner.
// The input stream carries one word per FASTA text byte: s_axis_tdata holds the
// byte and s_axis_tlast marks end of input, which closes any open scaffold and
// returns the parser to its before-first-header state.
// The output stream carries length records: m_axis_tdata is the length in bases,
// m_axis_tuser is the record kind (0 contig, 1 scaffold) and m_axis_tlast marks
// the final record caused by one input word.
// An input word that causes records has them written into a four-entry queue
// by the front parser when it is accepted, and the back stage then moves them
// into the output register, from which the first record is sent.
// Throughput is one input word per cycle while the queue has room; the output
// register sends one record per cycle while m_axis_tready is high, so a word that
// closes a scaffold with an open contig sends a contig then a scaffold record.
// When the receiver stalls, the queue absorbs up to four words worth of records
// before s_axis_tready drops; words that cause no records also wait while it is full.
// Reset clears the parser, the queue and the output valid; the block is ready
// for input as soon as reset is released.
module fasta_contig_length_scanner_top #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // end_of_file
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] length_bases
	output logic        m_axis_tuser,   // [0] record_kind
	output logic        m_axis_tlast    // last_of_run
);
	import fcls_pkg::*;

	logic            in_accept;
	logic            push;
	logic            pop;
	fcls_evt_t       push_evt;
	fcls_evt_t       head_evt;
	fcls_fifo_stat_t fifo_stat;

	// Input is taken whenever the queue has room for the records of one word.
	assign s_axis_tready = !fifo_stat.full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Front: parses each byte, keeps the counters and builds queue entries.
	fcls_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.text_byte  (s_axis_tdata),
		.end_of_file(s_axis_tlast),
		.push       (push),
		.evt        (push_evt)
	);

	// Queue that decouples parsing from the output handshake.
	fcls_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_evt(push_evt),
		.pop   (pop),
		.rd_evt(head_evt),
		.stat  (fifo_stat)
	);

	// Back: splits each entry into one record per output word.
	fcls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_evt  (head_evt),
		.head_empty(fifo_stat.empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_len   (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// A scaffold record always ends the records of its input word.
	a_scaffold_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_SCAFFOLD |-> m_axis_tlast)
		else $error("scaffold record without tlast");

	// A contig record that is not last is followed at once by its scaffold record.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		|=> m_axis_tvalid && m_axis_tuser == KIND_SCAFFOLD)
		else $error("scaffold record did not follow its contig record");

	// The queue never overflows or underflows, and its fill never passes its depth.
	a_fifo_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && fifo_stat.full && !pop) && !(pop && fifo_stat.empty)
		&& (fifo_stat.count <= (FIFO_AW+1)'(FIFO_DEPTH)))
		else $error("event queue overflow or underflow");

endmodule

// ===== rtl/fcls_front.sv =====
module fcls_front #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            text_byte,
	input  logic                  end_of_file,
	output logic                  push,
	output fcls_pkg::fcls_evt_t   evt
);
	import fcls_pkg::*;

	typedef enum logic [2:0] {
		MODE_BEFORE = 3'b001,
		MODE_HEADER = 3'b010,
		MODE_SEQ    = 3'b100
	} mode_t;

	localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

	mode_t                  mode_q, mode_d;
	logic [LENGTH_BITS-1:0] scaf_q, scaf_d;
	logic [LENGTH_BITS-1:0] contig_q, contig_d;
	logic                   gap_q, gap_d;
	logic                   seen_q, seen_d;
	logic                   push_c;
	logic [REC_BITS-1:0]    scaf32, contig32;

	// Reported lengths saturate at the record width.
	generate
		if (LENGTH_BITS > REC_BITS) begin : g_sat
			assign scaf32   = (|scaf_q[LENGTH_BITS-1:REC_BITS]) ? '1 : scaf_q[REC_BITS-1:0];
			assign contig32 = (|contig_q[LENGTH_BITS-1:REC_BITS]) ? '1 :
				contig_q[REC_BITS-1:0];
		end else begin : g_ext
			assign scaf32   = REC_BITS'(scaf_q);
			assign contig32 = REC_BITS'(contig_q);
		end
	endgenerate

	always_comb begin
		mode_d   = mode_q;
		scaf_d   = scaf_q;
		contig_d = contig_q;
		gap_d    = gap_q;
		seen_d   = seen_q;
		push_c   = 1'b0;
		evt      = '0;
		if (end_of_file || (mode_q == MODE_SEQ && text_byte == CH_GT)) begin
			// Scaffold close, either by a new header or by end of input.
			if (mode_q != MODE_BEFORE) begin
				push_c             = 1'b1;
				evt.has_contig     = !gap_q || !seen_q;
				evt.contig_len     = gap_q ? '0 : contig32;
				evt.has_scaffold   = 1'b1;
				evt.scaffold_len   = scaf32;
			end
			mode_d   = end_of_file ? MODE_BEFORE : MODE_HEADER;
			scaf_d   = '0;
			contig_d = '0;
			gap_d    = 1'b1;
			seen_d   = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_HEADER: begin
					if (text_byte == CH_LF || text_byte == CH_CR) begin
						mode_d = MODE_SEQ;
					end
				end
				MODE_SEQ: begin
					if (is_base(text_byte)) begin
						scaf_d = (scaf_q == CNT_MAX) ? scaf_q : scaf_q + 1'b1;
						if (text_byte == CH_N_UP || text_byte == CH_N_LO) begin
							if (!gap_q) begin
								push_c         = 1'b1;
								evt.has_contig = 1'b1;
								evt.contig_len = contig32;
								contig_d       = '0;
								gap_d          = 1'b1;
							end
						end else begin
							contig_d = (contig_q == CNT_MAX) ? contig_q : contig_q + 1'b1;
							gap_d    = 1'b0;
							seen_d   = 1'b1;
						end
					end
				end
				MODE_BEFORE: begin
					if (text_byte == CH_GT) begin
						mode_d   = MODE_HEADER;
						scaf_d   = '0;
						contig_d = '0;
						gap_d    = 1'b1;
						seen_d   = 1'b0;
					end
				end
				default: mode_d = MODE_BEFORE;
			endcase
		end
	end

	assign push = accept && push_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BEFORE;
			scaf_q   <= '0;
			contig_q <= '0;
			gap_q    <= 1'b1;
			seen_q   <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			scaf_q   <= scaf_d;
			contig_q <= contig_d;
			gap_q    <= gap_d;
			seen_q   <= seen_d;
		end
	end

endmodule

// ===== rtl/fcls_fifo.sv =====
module fcls_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  fcls_pkg::fcls_evt_t       wr_evt,
	input  logic                      pop,
	output fcls_pkg::fcls_evt_t       rd_evt,
	output fcls_pkg::fcls_fifo_stat_t stat
);
	import fcls_pkg::*;

	fcls_evt_t          entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign rd_evt     = entry_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/fcls_back.sv =====
module fcls_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fcls_pkg::fcls_evt_t        head_evt,
	input  logic                       head_empty,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_kind,
	output logic [fcls_pkg::REC_BITS-1:0] out_len,
	output logic                       out_last
);
	import fcls_pkg::*;

	fcls_evt_t cur_q;
	logic      pend_c_q, pend_s_q;

	fcls_evt_t src;
	logic      src_c, src_s, src_valid, from_head, slot_free, load;

	// Finish a partly sent entry before taking the next one from the queue.
	assign from_head = !(pend_c_q || pend_s_q);
	assign src       = from_head ? head_evt : cur_q;
	assign src_c     = from_head ? head_evt.has_contig : pend_c_q;
	assign src_s     = from_head ? head_evt.has_scaffold : pend_s_q;
	assign src_valid = from_head ? !head_empty : 1'b1;
	assign slot_free = !out_valid || out_ready;
	assign load      = slot_free && src_valid;
	assign pop       = load && from_head;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= src;
			if (src_c) begin
				out_kind <= KIND_CONTIG;
				out_len  <= src.contig_len;
				out_last <= !src_s;
			end else begin
				out_kind <= KIND_SCAFFOLD;
				out_len  <= src.scaffold_len;
				out_last <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pend_c_q  <= 1'b0;
			pend_s_q  <= 1'b0;
		end else if (slot_free) begin
			out_valid <= src_valid;
			if (load) begin
				pend_c_q <= 1'b0;
				pend_s_q <= src_c && src_s;
			end
		end
	end

endmodule
